>>> rtl/wawr_pkg.sv
// ----------------------------------------------------------------------------
// wawr_pkg
// types, constants and helpers shared by the width-aware word wrap block
// ----------------------------------------------------------------------------
package wawr_pkg;

	// field widths fixed by the channel formats
	localparam int CHAR_W     = 16;
	localparam int ROW_W      = 4;
	localparam int COL_W      = 5;
	localparam int LCNT_W     = 5;
	localparam int ML_W       = 5;
	localparam int LS_W       = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int RES_CNT_W  = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE = 1'b1;

	localparam logic [ML_W-1:0] RESET_MAX_LINES = 5'd16;
	localparam logic [LS_W-1:0] RESET_LINE_SIZE = 6'd32;

	// results one input word may produce
	localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 6'd36;

	localparam logic [CHAR_W-1:0] SPACE_CODE = 16'h0020;

	// full-width code ranges
	localparam int WIDE_N = 8;
	localparam logic [CHAR_W-1:0] WIDE_LO [WIDE_N] = '{
		16'h1100, 16'h2E80, 16'hA000, 16'hAC00,
		16'hF900, 16'hFE30, 16'hFF00, 16'hFFE0
	};
	localparam logic [CHAR_W-1:0] WIDE_HI [WIDE_N] = '{
		16'h115F, 16'h9FFF, 16'hA4CF, 16'hD7A3,
		16'hFAFF, 16'hFE4F, 16'hFF60, 16'hFFE6
	};

	function automatic logic is_wide(input logic [CHAR_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < WIDE_N; i++) begin
			if (c >= WIDE_LO[i] && c <= WIDE_HI[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SUMM,
		ST_RPL,
		ST_LOOP,
		ST_HTERM
	} wawr_state_t;

	// what the output word carries
	typedef enum logic [2:0] {
		SEL_CHAR,
		SEL_RPL,
		SEL_TERM_SPC,
		SEL_TERM_WCOL,
		SEL_TERM_NEXT,
		SEL_SUM_ZERO,
		SEL_SUM_ROWS,
		SEL_SUM_CUR
	} emit_sel_t;

	typedef struct packed {
		logic      in_ready;
		logic      load;
		logic      clear;
		logic      emit;
		emit_sel_t sel;
		logic      last;
		logic      wr_c;
		logic      wr_r;
		logic      adv;
		logic      set_space;
		logic      next_row;
		logic      set_full;
		logic      set_skip;
		logic      clr_skip;
		logic      rpl_start;
		logic      rpl_adv;
	} wawr_cmd_t;

	typedef struct packed {
		logic is_end;
		logic cfg_zero;
		logic rows_full;
		logic row_over;
		logic last_row;
		logic skip;
		logic is_space;
		logic fits;
		logic space_seen;
		logic rw_zero;
		logic cells_gt1;
		logic rpl_more;
		logic out_free;
	} wawr_status_t;

endpackage

>>> rtl/wawr_char_if.sv
// ----------------------------------------------------------------------------
// wawr_char_if
// character input channel: one code unit or an end mark per word
// ----------------------------------------------------------------------------
interface wawr_char_if;
	logic                          valid;
	logic                          ready;
	logic [wawr_pkg::CHAR_W-1:0]   char_code;
	logic                          is_end;

	modport source(output valid, output char_code, output is_end, input ready);
	modport sink(input valid, input char_code, input is_end, output ready);
endinterface

>>> rtl/wawr_cell_if.sv
// ----------------------------------------------------------------------------
// wawr_cell_if
// result channel: one written cell or the final line count per word
// ----------------------------------------------------------------------------
interface wawr_cell_if;
	logic                          valid;
	logic                          ready;
	logic [wawr_pkg::ROW_W-1:0]    row;
	logic [wawr_pkg::COL_W-1:0]    column;
	logic [wawr_pkg::CHAR_W-1:0]   cell_value;
	logic                          is_summary;
	logic [wawr_pkg::LCNT_W-1:0]   line_count;
	logic                          last;

	modport source(output valid, output row, output column, output cell_value,
		output is_summary, output line_count, output last, input ready);
	modport sink(input valid, input row, input column, input cell_value,
		input is_summary, input line_count, input last, output ready);
endinterface

>>> rtl/wawr_cfg_if.sv
// ----------------------------------------------------------------------------
// wawr_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface wawr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [wawr_pkg::CFG_IDX_W-1:0]    index;
	logic [wawr_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/width_aware_word_wrap.sv
// ----------------------------------------------------------------------------
// width_aware_word_wrap
// greedy word wrap of 16-bit code units into rows, full-width aware
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake      payload
//   char_ch   in   valid/ready    char_code[15:0], is_end
//   cell_ch   out  valid/ready    row[3:0], column[4:0], cell_value[15:0],
//                                 is_summary, line_count[4:0], last
//   cfg       in   valid/ready    index[0] (0 max_lines, 1 line_size), data[5:0]
//
// a plain character is taken in the idle state, then decided and its cell
// written into the output register
// a wrap at a space emits the terminator, then replays each character after
// the space from the line store (one read port), leaves the replay and
// takes the normal step
// a hard break ends the row with a terminator; end of text ends with the summary
// arst_n clears the sequencer, the row state and the output valid; the
// registers come back as max_lines 16, line_size 32; cfg is always ready
// a stalled output holds the sequencer in place; char_ch is ready only
// between words, while a finished word can still sit in the output register
// ----------------------------------------------------------------------------
module width_aware_word_wrap #(
	parameter int LINE_MAX = 32,
	parameter int ROWS_MAX = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	wawr_char_if.sink    char_ch,
	wawr_cell_if.source  cell_ch,
	wawr_cfg_if.sink     cfg
);

	// command and status between sequencer and datapath
	wawr_pkg::wawr_cmd_t    cmd;
	wawr_pkg::wawr_status_t st;

	// input handshake is owned by the sequencer (ready only in its idle state)
	assign char_ch.ready = cmd.in_ready;

	// sequencer: fit, cut at last space with replay, hard break, end of text
	wawr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_ch.valid),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: registers, row counters, line store and output word register
	wawr_dp #(
		.LINE_MAX (LINE_MAX),
		.ROWS_MAX (ROWS_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.char_code (char_ch.char_code),
		.is_end    (char_ch.is_end),
		.cfg       (cfg),
		.cell_ch   (cell_ch)
	);

endmodule

>>> rtl/wawr_ctrl.sv
// ----------------------------------------------------------------------------
// wawr_ctrl
// sequencer for the word wrap: unless the output stalls, one decision or one result per cycle
// ----------------------------------------------------------------------------
module wawr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	input  wawr_pkg::wawr_status_t st,
	output wawr_pkg::wawr_cmd_t    cmd
);

	wawr_pkg::wawr_state_t state_q, state_d;
	wawr_pkg::wawr_state_t step_next;
	wawr_pkg::wawr_cmd_t   step_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wawr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one pass of the fit / cut / hard break decision
	always_comb begin
		step_cmd  = '0;
		step_next = state_q;
		if (st.out_free) begin
			step_cmd.emit      = 1'b1;
			step_cmd.set_space = st.is_space;
			if (st.fits) begin
				step_cmd.sel  = wawr_pkg::SEL_CHAR;
				step_cmd.last = 1'b1;
				step_cmd.wr_c = 1'b1;
				step_cmd.adv  = 1'b1;
				step_next     = wawr_pkg::ST_IDLE;
			end else if (st.space_seen && !st.is_space) begin
				step_cmd.sel      = wawr_pkg::SEL_TERM_SPC;
				step_cmd.last     = st.last_row;
				step_cmd.next_row = 1'b1;
				if (st.last_row) begin
					step_cmd.set_full = 1'b1;
					step_next         = wawr_pkg::ST_IDLE;
				end else begin
					step_cmd.rpl_start = 1'b1;
					step_next          = wawr_pkg::ST_RPL;
				end
			end else if (st.rw_zero && st.cells_gt1) begin
				// lone too-wide character gets the row to itself
				step_cmd.sel  = wawr_pkg::SEL_CHAR;
				step_cmd.wr_c = 1'b1;
				step_next     = wawr_pkg::ST_HTERM;
			end else begin
				step_cmd.sel      = wawr_pkg::SEL_TERM_WCOL;
				step_cmd.last     = st.last_row || st.rw_zero || st.is_space;
				step_cmd.next_row = 1'b1;
				if (st.last_row) begin
					step_cmd.set_full = 1'b1;
					step_next         = wawr_pkg::ST_IDLE;
				end else if (st.rw_zero || st.is_space) begin
					step_cmd.set_skip = 1'b1;
					step_next         = wawr_pkg::ST_IDLE;
				end else begin
					step_next = wawr_pkg::ST_LOOP;
				end
			end
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			wawr_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (char_valid) begin
					cmd.load = 1'b1;
					state_d  = wawr_pkg::ST_EVAL;
				end
			end
			wawr_pkg::ST_EVAL: begin
				if (st.is_end) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						if (st.cfg_zero) begin
							cmd.sel   = wawr_pkg::SEL_SUM_ZERO;
							cmd.last  = 1'b1;
							cmd.clear = 1'b1;
							state_d   = wawr_pkg::ST_IDLE;
						end else if (st.rows_full || st.row_over) begin
							cmd.sel   = wawr_pkg::SEL_SUM_ROWS;
							cmd.last  = 1'b1;
							cmd.clear = 1'b1;
							state_d   = wawr_pkg::ST_IDLE;
						end else begin
							cmd.sel = wawr_pkg::SEL_TERM_WCOL;
							state_d = wawr_pkg::ST_SUMM;
						end
					end
				end else if (st.cfg_zero || st.rows_full) begin
					state_d = wawr_pkg::ST_IDLE;
				end else if (st.row_over) begin
					cmd.set_full = 1'b1;
					state_d      = wawr_pkg::ST_IDLE;
				end else if (st.skip && st.is_space) begin
					state_d = wawr_pkg::ST_IDLE;
				end else begin
					cmd          = step_cmd;
					cmd.clr_skip = st.skip;
					state_d      = step_next;
				end
			end
			wawr_pkg::ST_SUMM: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					cmd.sel   = wawr_pkg::SEL_SUM_CUR;
					cmd.last  = 1'b1;
					cmd.clear = 1'b1;
					state_d   = wawr_pkg::ST_IDLE;
				end
			end
			wawr_pkg::ST_RPL: begin
				if (st.rpl_more) begin
					if (st.out_free) begin
						cmd.emit    = 1'b1;
						cmd.sel     = wawr_pkg::SEL_RPL;
						cmd.wr_r    = 1'b1;
						cmd.adv     = 1'b1;
						cmd.rpl_adv = 1'b1;
					end
				end else begin
					state_d = wawr_pkg::ST_LOOP;
				end
			end
			wawr_pkg::ST_LOOP: begin
				cmd     = step_cmd;
				state_d = step_next;
			end
			wawr_pkg::ST_HTERM: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = wawr_pkg::SEL_TERM_NEXT;
					cmd.last     = 1'b1;
					cmd.next_row = 1'b1;
					if (st.last_row) begin
						cmd.set_full = 1'b1;
					end else begin
						cmd.set_skip = 1'b1;
					end
					state_d = wawr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wawr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/wawr_dp.sv
// ----------------------------------------------------------------------------
// wawr_dp
// row state, line store, registers and the output word register
// ----------------------------------------------------------------------------
module wawr_dp #(
	parameter int LINE_MAX = 32,
	parameter int ROWS_MAX = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wawr_pkg::wawr_cmd_t           cmd,
	output wawr_pkg::wawr_status_t        st,
	input  logic [wawr_pkg::CHAR_W-1:0]   char_code,
	input  logic                          is_end,
	wawr_cfg_if.sink                      cfg,
	wawr_cell_if.source                   cell_ch
);

	localparam int CW    = $clog2(LINE_MAX + 1);
	localparam int AW    = $clog2(LINE_MAX);
	localparam int RWW   = CW + 1;
	localparam int COL_W = wawr_pkg::COL_W;

	// registers
	logic [wawr_pkg::ML_W-1:0] max_lines_q;
	logic [wawr_pkg::LS_W-1:0] line_size_q;

	// current word
	logic [wawr_pkg::CHAR_W-1:0] c_q;
	logic                        end_q;
	logic [wawr_pkg::RES_CNT_W-1:0] cnt_q;

	// row state
	logic [wawr_pkg::ML_W-1:0] cur_q;
	logic [RWW-1:0]            rw_q;
	logic [CW-1:0]             wcol_q;
	logic [CW-1:0]             spc_q;
	logic                      sps_q;
	logic                      skip_q;
	logic                      full_q;
	logic [CW-1:0]             rd_q;
	logic [CW-1:0]             rend_q;

	// line store
	logic [wawr_pkg::CHAR_W-1:0] mem [LINE_MAX];
	logic [wawr_pkg::CHAR_W-1:0] rdata_q;
	logic [wawr_pkg::CHAR_W-1:0] wdata;
	logic [CW-1:0]               raddr_full;
	logic                        mem_we;

	// output word
	logic                          out_v_q;
	logic [wawr_pkg::ROW_W-1:0]    row_q;
	logic [COL_W-1:0]              col_q;
	logic [wawr_pkg::CHAR_W-1:0]   val_q;
	logic                          summ_q;
	logic [wawr_pkg::LCNT_W-1:0]   lcnt_q;
	logic                          last_q;

	logic [wawr_pkg::ML_W-1:0]   rows_eff;
	logic [CW-1:0]               cells_eff;
	logic [RWW-1:0]              limit;
	logic [1:0]                  wc, wr;
	logic                        cap, emit_wr;
	logic [CW-1:0]               col_d;
	logic [wawr_pkg::CHAR_W-1:0] val_d;
	logic                        summ_d;
	logic [wawr_pkg::LCNT_W-1:0] lcnt_d;

	assign rows_eff  = (int'(max_lines_q) > ROWS_MAX) ? wawr_pkg::ML_W'(ROWS_MAX)
		: max_lines_q;
	assign cells_eff = (int'(line_size_q) > LINE_MAX) ? CW'(LINE_MAX) : CW'(line_size_q);
	assign limit     = RWW'(cells_eff) - RWW'(1);
	assign wc        = wawr_pkg::is_wide(c_q) ? 2'd2 : 2'd1;
	assign wr        = wawr_pkg::is_wide(rdata_q) ? 2'd2 : 2'd1;
	assign cap       = cnt_q >= wawr_pkg::MAX_RESULTS;
	assign emit_wr   = cmd.emit && !cap;

	assign st.is_end     = end_q || (c_q == '0);
	assign st.cfg_zero   = (rows_eff == '0) || (cells_eff == '0);
	assign st.rows_full  = full_q;
	assign st.row_over   = cur_q >= rows_eff;
	assign st.last_row   = ({1'b0, cur_q} + 6'd1) >= {1'b0, rows_eff};
	assign st.skip       = skip_q;
	assign st.is_space   = c_q == wawr_pkg::SPACE_CODE;
	assign st.fits       = (rw_q + RWW'(wc)) <= limit;
	assign st.space_seen = sps_q;
	assign st.rw_zero    = rw_q == '0;
	assign st.cells_gt1  = cells_eff > CW'(1);
	assign st.rpl_more   = rd_q < rend_q;
	assign st.out_free   = cap || !out_v_q || cell_ch.ready;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lines_q <= wawr_pkg::RESET_MAX_LINES;
			line_size_q <= wawr_pkg::RESET_LINE_SIZE;
		end else if (cfg.valid) begin
			case (cfg.index)
				wawr_pkg::CFG_MAX_LINES: max_lines_q <= cfg.data[wawr_pkg::ML_W-1:0];
				wawr_pkg::CFG_LINE_SIZE: line_size_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q   <= char_code;
			end_q <= is_end;
		end
	end

	// result counter per input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (emit_wr) begin
			cnt_q <= cnt_q + wawr_pkg::RES_CNT_W'(1);
		end
	end

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			rw_q   <= '0;
			wcol_q <= '0;
			spc_q  <= '0;
			sps_q  <= 1'b0;
			skip_q <= 1'b0;
			full_q <= 1'b0;
			rd_q   <= '0;
			rend_q <= '0;
		end else if (cmd.clear) begin
			cur_q  <= '0;
			rw_q   <= '0;
			wcol_q <= '0;
			spc_q  <= '0;
			sps_q  <= 1'b0;
			skip_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (cmd.adv) begin
				wcol_q <= wcol_q + CW'(1);
				rw_q   <= rw_q + RWW'(cmd.wr_r ? wr : wc);
			end
			if (cmd.set_space) begin
				sps_q <= 1'b1;
				spc_q <= wcol_q;
			end
			if (cmd.next_row) begin
				cur_q  <= cur_q + wawr_pkg::ML_W'(1);
				wcol_q <= '0;
				rw_q   <= '0;
				sps_q  <= 1'b0;
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
			if (cmd.clr_skip) begin
				skip_q <= 1'b0;
			end
			if (cmd.set_skip) begin
				skip_q <= 1'b1;
			end
			if (cmd.rpl_start) begin
				rd_q   <= spc_q + CW'(1);
				rend_q <= wcol_q;
			end else if (cmd.rpl_adv) begin
				rd_q <= rd_q + CW'(1);
			end
		end
	end

	// line store: one write and one registered read per cycle
	assign mem_we     = cmd.wr_c || cmd.wr_r;
	assign wdata      = cmd.wr_r ? rdata_q : c_q;
	assign raddr_full = cmd.rpl_start ? (spc_q + CW'(1))
		: (cmd.rpl_adv ? (rd_q + CW'(1)) : rd_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wcol_q[AW-1:0]] <= wdata;
		end
		if (raddr_full < CW'(LINE_MAX)) begin
			rdata_q <= mem[raddr_full[AW-1:0]];
		end
	end

	// result payload
	always_comb begin
		col_d  = '0;
		val_d  = '0;
		summ_d = 1'b0;
		lcnt_d = '0;
		case (cmd.sel)
			wawr_pkg::SEL_CHAR: begin
				col_d = wcol_q;
				val_d = c_q;
			end
			wawr_pkg::SEL_RPL: begin
				col_d = wcol_q;
				val_d = rdata_q;
			end
			wawr_pkg::SEL_TERM_SPC:  col_d = spc_q;
			wawr_pkg::SEL_TERM_WCOL: col_d = wcol_q;
			wawr_pkg::SEL_TERM_NEXT: col_d = wcol_q + CW'(1);
			wawr_pkg::SEL_SUM_ZERO:  summ_d = 1'b1;
			wawr_pkg::SEL_SUM_ROWS: begin
				summ_d = 1'b1;
				lcnt_d = rows_eff;
			end
			wawr_pkg::SEL_SUM_CUR: begin
				summ_d = 1'b1;
				lcnt_d = cur_q + wawr_pkg::LCNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit_wr) begin
			out_v_q <= 1'b1;
		end else if (cell_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_wr) begin
			row_q  <= summ_d ? '0 : cur_q[wawr_pkg::ROW_W-1:0];
			col_q  <= COL_W'(col_d);
			val_q  <= val_d;
			summ_q <= summ_d;
			lcnt_q <= lcnt_d;
			last_q <= cmd.last || (cnt_q == (wawr_pkg::MAX_RESULTS - 6'd1));
		end
	end

	assign cell_ch.valid      = out_v_q;
	assign cell_ch.row        = row_q;
	assign cell_ch.column     = col_q;
	assign cell_ch.cell_value = val_q;
	assign cell_ch.is_summary = summ_q;
	assign cell_ch.line_count = lcnt_q;
	assign cell_ch.last       = last_q;

endmodule
